[rtl/sws_pkg.sv]
// Shared types and constants for the sliding window sum smoother.
`default_nettype none

package sws_pkg;

  // Width of the smoothed result field and of its padded stream word.
  localparam int OUT_W       = 22;
  localparam int OUT_TDATA_W = 24;

  // Half window configuration register.
  localparam int         HALF_W     = 5;
  localparam logic [4:0] HALF_RESET = 5'd2;

  // One result item on its way to the output register.
  typedef struct packed {
    logic [OUT_W-1:0] smoothed;
    logic             passthrough;
    logic             last_result;
  } sws_item_t;

endpackage

`default_nettype wire

[rtl/sws_out_stage.sv]
// Output register stage that holds one result transaction for the receiver.
`default_nettype none

module sws_out_stage (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               load_valid,
  input  wire sws_pkg::sws_item_t           load_item,
  output logic                              load_ready,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  output logic [sws_pkg::OUT_TDATA_W-1:0]   out_tdata,   // [21:0] smoothed, rest zero
  output logic [0:0]                        out_tuser,   // [0] passthrough
  output logic                              out_tlast    // last_result
);
  import sws_pkg::*;

  logic      valid_r;
  sws_item_t item_r;

  // The register can take a new result when empty or being drained this cycle.
  assign load_ready = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_ready) begin
      valid_r <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ready && load_valid) begin
      item_r <= load_item;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-OUT_W){1'b0}}, item_r.smoothed};
  assign out_tuser  = item_r.passthrough;
  assign out_tlast  = item_r.last_result;

endmodule

`default_nettype wire

[rtl/sliding_window_sum_smoother.sv]
// Top level of the sliding window sum smoother.
//
// A record of samples enters on the in_ stream, one per transaction, with
// in_tlast on the final sample. For each position the out_ stream returns the
// sum of the centered window of 2h+1 samples; the first h+1 and the last h+1
// results repeat the edge sums, and out_tlast marks the final result. A record
// shorter than one window comes back sample by sample with out_tuser set.
// The cfg_ port writes h; it is taken only while the block is idle and drops
// any partial record.
// Timing: an input transaction is accepted in the idle state while the oldest
// sample is read from the sample line memory, and the running total is updated
// in the S_EXEC state that follows; no new sample is taken until the block is
// idle again. Each result passes through the output register, so the bursts of
// h+1 results at window fill and at record end are handed over one by one; a
// returned short record reads each held sample from the memory in turn.
// Reset clears the total, the fill count and h (to 2); the memory contents
// are not cleared, and no value read from them is used before being written.
// When the receiver stalls, the pending result holds and input is accepted
// again once the block has handed its last result to the output register.
`default_nettype none

module sliding_window_sum_smoother #(
  parameter int MAX_HALF_WINDOW = 31,
  parameter int SAMPLE_BITS     = 16
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_tvalid,
  output logic                                  in_tready,
  input  wire  [((SAMPLE_BITS+7)/8)*8-1:0]      in_tdata,   // [SAMPLE_BITS-1:0] sample
  input  wire                                   in_tlast,   // last_sample
  output logic                                  out_tvalid,
  input  wire                                   out_tready,
  output logic [sws_pkg::OUT_TDATA_W-1:0]       out_tdata,  // [21:0] smoothed
  output logic [0:0]                            out_tuser,  // [0] passthrough
  output logic                                  out_tlast,  // last_result
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire  [sws_pkg::HALF_W-1:0]            cfg_data    // half_window
);
  import sws_pkg::*;

  localparam int LINE_DEPTH = 2 * MAX_HALF_WINDOW + 1;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int CNT_W      = $clog2(LINE_DEPTH + 1);
  localparam int EXT_W      = (SAMPLE_BITS > OUT_W) ? SAMPLE_BITS : OUT_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_COPY  = 3'd2;
  localparam logic [2:0] S_DREAD = 3'd3;
  localparam logic [2:0] S_DOUT  = 3'd4;
  localparam logic [2:0] S_XOUT  = 3'd5;

  logic [2:0]             state_r, state_nxt;
  logic [HALF_W-1:0]      half_r;
  logic [CNT_W-1:0]       fill_r, fill_nxt;
  logic [OUT_W-1:0]       total_r, total_nxt;
  logic [ADDR_W-1:0]      head_r, head_nxt;
  logic [ADDR_W-1:0]      idx_r, idx_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [OUT_W-1:0]       emit_val_r, emit_val_nxt;
  logic                   emit_last_r, emit_last_nxt;
  logic [SAMPLE_BITS-1:0] x_r;
  logic                   last_r;

  logic [SAMPLE_BITS-1:0] line_mem [LINE_DEPTH];
  logic [SAMPLE_BITS-1:0] rd_data_r;
  logic [ADDR_W-1:0]      rd_addr;
  logic [ADDR_W-1:0]      wr_addr;
  logic                   mem_we;

  logic [HALF_W-1:0]      h_eff;
  logic [CNT_W-1:0]       win;
  logic [CNT_W-1:0]       h_plus1;
  logic [EXT_W-1:0]       x_ext;
  logic [EXT_W-1:0]       rd_ext;
  logic [OUT_W-1:0]       x_out;
  logic [OUT_W-1:0]       rd_out;
  logic [OUT_W-1:0]       sum_add;
  logic [OUT_W-1:0]       sum_slide;

  logic                   in_acc;
  logic                   cfg_acc;
  logic                   load_valid;
  sws_item_t              load_item;
  logic                   load_ready;

  // Effective half width, limited to what the sample line can hold.
  assign h_eff   = (half_r > HALF_W'(MAX_HALF_WINDOW)) ? HALF_W'(MAX_HALF_WINDOW) : half_r;
  assign win     = CNT_W'({h_eff, 1'b1});
  assign h_plus1 = CNT_W'(h_eff) + CNT_W'(1);

  assign x_ext     = EXT_W'(x_r);
  assign rd_ext    = EXT_W'(rd_data_r);
  assign x_out     = x_ext[OUT_W-1:0];
  assign rd_out    = rd_ext[OUT_W-1:0];
  assign sum_add   = total_r + x_out;
  assign sum_slide = total_r - rd_out + x_out;

  assign cfg_ready = (state_r == S_IDLE);
  assign in_tready = (state_r == S_IDLE) && !cfg_valid;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_acc    = in_tvalid && in_tready;

  // While idle the oldest sample is fetched so that it is ready for the update.
  assign rd_addr = (state_r == S_IDLE) ? head_r : idx_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[wr_addr] <= x_r;
    end
    rd_data_r <= line_mem[rd_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    total_nxt     = total_r;
    head_nxt      = head_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    emit_val_nxt  = emit_val_r;
    emit_last_nxt = emit_last_r;
    mem_we        = 1'b0;
    wr_addr       = fill_r[ADDR_W-1:0];
    load_valid    = 1'b0;
    load_item     = '{smoothed: emit_val_r, passthrough: 1'b0,
                      last_result: emit_last_r && (cnt_r == CNT_W'(1))};
    case (state_r)
      S_IDLE: begin
        if (cfg_acc) begin
          fill_nxt  = '0;
          total_nxt = '0;
          head_nxt  = '0;
        end else if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (fill_r == win) begin
          // Full window: drop the oldest sample and put the new one in its slot.
          mem_we        = 1'b1;
          wr_addr       = head_r;
          emit_val_nxt  = sum_slide;
          emit_last_nxt = last_r;
          cnt_nxt       = last_r ? h_plus1 : CNT_W'(1);
          state_nxt     = S_COPY;
          if (last_r) begin
            fill_nxt  = '0;
            total_nxt = '0;
            head_nxt  = '0;
          end else begin
            total_nxt = sum_slide;
            head_nxt  = (head_r == ADDR_W'(win - CNT_W'(1))) ? '0 : head_r + ADDR_W'(1);
          end
        end else if (!last_r) begin
          mem_we    = 1'b1;
          total_nxt = sum_add;
          fill_nxt  = fill_r + CNT_W'(1);
          if (fill_r + CNT_W'(1) == win) begin
            emit_val_nxt  = sum_add;
            emit_last_nxt = 1'b0;
            cnt_nxt       = h_plus1;
            state_nxt     = S_COPY;
          end else begin
            state_nxt = S_IDLE;
          end
        end else if (fill_r + CNT_W'(1) == win) begin
          // The record is exactly one window long: every result is that one sum.
          emit_val_nxt  = sum_add;
          emit_last_nxt = 1'b1;
          cnt_nxt       = win;
          state_nxt     = S_COPY;
          fill_nxt      = '0;
          total_nxt     = '0;
          head_nxt      = '0;
        end else begin
          // Short record: replay the held samples, then the final one.
          idx_nxt   = '0;
          state_nxt = (fill_r == '0) ? S_XOUT : S_DREAD;
        end
      end
      S_COPY: begin
        load_valid = 1'b1;
        if (load_ready) begin
          cnt_nxt = cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_DREAD: begin
        state_nxt = S_DOUT;
      end
      S_DOUT: begin
        load_valid = 1'b1;
        load_item  = '{smoothed: rd_out, passthrough: 1'b1, last_result: 1'b0};
        if (load_ready) begin
          idx_nxt   = idx_r + ADDR_W'(1);
          state_nxt = (CNT_W'(idx_r) + CNT_W'(1) == fill_r) ? S_XOUT : S_DREAD;
        end
      end
      S_XOUT: begin
        load_valid = 1'b1;
        load_item  = '{smoothed: x_out, passthrough: 1'b1, last_result: 1'b1};
        if (load_ready) begin
          fill_nxt  = '0;
          total_nxt = '0;
          head_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      half_r  <= HALF_RESET;
      fill_r  <= '0;
      total_r <= '0;
      head_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      total_r <= total_nxt;
      head_r  <= head_nxt;
      if (cfg_acc) begin
        half_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    cnt_r       <= cnt_nxt;
    emit_val_r  <= emit_val_nxt;
    emit_last_r <= emit_last_nxt;
    if (in_acc) begin
      x_r    <= in_tdata[SAMPLE_BITS-1:0];
      last_r <= in_tlast;
    end
  end

  sws_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (load_valid),
    .load_item  (load_item),
    .load_ready (load_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

[rtl/sws_checker.sv]
// Port-level checks for the sliding window sum smoother, bound to its top level.
`default_nettype none

module sws_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_tvalid,
  input wire                              in_tready,
  input wire                              out_tvalid,
  input wire                              out_tready,
  input wire [sws_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input wire [0:0]                        out_tuser,
  input wire                              out_tlast,
  input wire                              cfg_valid,
  input wire                              cfg_ready
);

  // Reset empties the output register.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result transaction pending right after reset");

  // A stalled result holds its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result transaction changed");

  // A returned short-record sample never carries bits above the sample width.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> (out_tdata >> SAMPLE_BITS) == '0)
    else $error("passthrough result wider than a sample");

  // No input is taken in a cycle that hands over a short-record sample other than the last.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser[0] && !out_tlast |-> !(in_tvalid && in_tready))
    else $error("input taken in the middle of a short-record replay");

  // A configuration write and an input item never land in the same cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tvalid && in_tready && cfg_valid && cfg_ready))
    else $error("configuration and input transactions collided");

endmodule

bind sliding_window_sum_smoother sws_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_sws_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);

`default_nettype wire
